>>> design/assert_macros.svh
// Assertion macros used by the transform matrix builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("next-cycle implication failed");

`endif

>>> design/trs_pkg.sv
// Shared constants of the transform matrix builder.
package trs_pkg;

   localparam int TRS_VALUE_WIDTH = 32;
   localparam int TRS_ANGLE_WIDTH = 17;
   localparam int TRS_SC_LATENCY  = 12;

   localparam logic [32:0] TRS_Q30_ONE  = 33'h0_4000_0000;
   localparam logic [60:0] TRS_Q30_HALF = 61'h2000_0000;

   localparam logic [17:0] TRS_DEG360 = 18'd46080;
   localparam logic [17:0] TRS_DEG720 = 18'd92160;
   localparam logic [17:0] TRS_DEG1080 = 18'd138240;
   localparam logic [15:0] TRS_DEG90  = 16'd11520;
   localparam logic [15:0] TRS_DEG180 = 16'd23040;
   localparam logic [15:0] TRS_DEG270 = 16'd34560;
   localparam logic [13:0] TRS_DEG45  = 14'd5760;

   localparam logic [63:0] TRS_PI_Q60 = 64'h3243_F6A8_885A_308D;
   localparam logic [47:0] TRS_RAD_K  = 48'(TRS_PI_Q60 / 64'd23040);

   // reciprocals for exact floor division of 30-bit values
   localparam int TRS_SH_6       = 33;
   localparam int TRS_SH_24      = 35;
   localparam int TRS_SH_120     = 37;
   localparam int TRS_SH_720     = 40;
   localparam int TRS_SH_5040    = 43;
   localparam int TRS_SH_40320   = 46;
   localparam int TRS_SH_362880  = 49;
   localparam int TRS_SH_3628800 = 52;
   localparam logic [31:0] TRS_RCP_6 =
      32'(((64'd1 << TRS_SH_6) + 64'd5) / 64'd6);
   localparam logic [31:0] TRS_RCP_24 =
      32'(((64'd1 << TRS_SH_24) + 64'd23) / 64'd24);
   localparam logic [31:0] TRS_RCP_120 =
      32'(((64'd1 << TRS_SH_120) + 64'd119) / 64'd120);
   localparam logic [31:0] TRS_RCP_720 =
      32'(((64'd1 << TRS_SH_720) + 64'd719) / 64'd720);
   localparam logic [31:0] TRS_RCP_5040 =
      32'(((64'd1 << TRS_SH_5040) + 64'd5039) / 64'd5040);
   localparam logic [31:0] TRS_RCP_40320 =
      32'(((64'd1 << TRS_SH_40320) + 64'd40319) / 64'd40320);
   localparam logic [31:0] TRS_RCP_362880 =
      32'(((64'd1 << TRS_SH_362880) + 64'd362879) / 64'd362880);
   localparam logic [31:0] TRS_RCP_3628800 =
      32'(((64'd1 << TRS_SH_3628800) + 64'd3628799) / 64'd3628800);

   localparam logic [1:0] TRS_COL_LAST = 2'd3;

endpackage

>>> design/trs_sincos.sv
// Pipelined sine and cosine in Q30 of an angle in 1/128 degree units.
module trs_sincos (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   input  logic signed [trs_pkg::TRS_ANGLE_WIDTH-1:0] angle,
   output logic                                     out_valid,
   output logic signed [31:0]                       sin_q30,
   output logic signed [31:0]                       cos_q30
);
   import trs_pkg::*;

   function automatic logic [29:0] umul30(input logic [29:0] a, input logic [29:0] b);
      logic [60:0] pr;
      pr = 61'(a) * 61'(b) + TRS_Q30_HALF;
      return 30'(pr >> 30);
   endfunction

   function automatic logic [29:0] rdiv(input logic [29:0] p, input logic [31:0] m,
                                        input int sh);
      logic [61:0] pr;
      pr = 62'(p) * 62'(m);
      return 30'(pr >> sh);
   endfunction

   // truncated Taylor term p_k / k!
   function automatic logic [29:0] term_of(input int k, input logic [29:0] p);
      logic [29:0] t;
      case (k)
         1:       t = p;
         2:       t = p >> 1;
         3:       t = rdiv(p, TRS_RCP_6, TRS_SH_6);
         4:       t = rdiv(p, TRS_RCP_24, TRS_SH_24);
         5:       t = rdiv(p, TRS_RCP_120, TRS_SH_120);
         6:       t = rdiv(p, TRS_RCP_720, TRS_SH_720);
         7:       t = rdiv(p, TRS_RCP_5040, TRS_SH_5040);
         8:       t = rdiv(p, TRS_RCP_40320, TRS_SH_40320);
         9:       t = rdiv(p, TRS_RCP_362880, TRS_SH_362880);
         10:      t = rdiv(p, TRS_RCP_3628800, TRS_SH_3628800);
         default: t = '0;
      endcase
      return t;
   endfunction

   // angle reduction
   logic signed [18:0] a_bias;
   logic [17:0]        u;
   logic [15:0]        m;
   logic [1:0]         q;
   logic [13:0]        r;

   always_comb begin
      a_bias = 19'(angle) + 19'sd92160;
      u = 18'(a_bias);
      if (u >= TRS_DEG1080) begin
         m = 16'(u - TRS_DEG1080);
      end else if (u >= TRS_DEG720) begin
         m = 16'(u - TRS_DEG720);
      end else if (u >= TRS_DEG360) begin
         m = 16'(u - TRS_DEG360);
      end else begin
         m = 16'(u);
      end
      if (m >= TRS_DEG270) begin
         q = 2'd3;
         r = 14'(m - TRS_DEG270);
      end else if (m >= TRS_DEG180) begin
         q = 2'd2;
         r = 14'(m - TRS_DEG180);
      end else if (m >= TRS_DEG90) begin
         q = 2'd1;
         r = 14'(m - TRS_DEG90);
      end else begin
         q = 2'd0;
         r = 14'(m);
      end
   end

   logic        red_v_ff;
   logic [13:0] red_r_ff;
   logic [1:0]  red_q_ff;

   // radians
   logic        sw;
   logic [12:0] rr;
   logic [60:0] xprod;
   logic [29:0] x;

   always_comb begin
      sw = red_r_ff > TRS_DEG45;
      rr = sw ? 13'(14'(TRS_DEG90) - red_r_ff) : 13'(red_r_ff);
      xprod = 61'(rr) * 61'(TRS_RAD_K);
      x = 30'((xprod + TRS_Q30_HALF) >> 30);
   end

   // series stages: stage k holds x^k and the sums of terms below k
   logic [10:1]        v_ff;
   logic [29:0]        p_ff    [1:10];
   logic [29:0]        x_ff    [1:10];
   logic signed [32:0] sacc_ff [1:10];
   logic signed [32:0] cacc_ff [1:10];
   logic [1:0]         q_ff    [1:10];
   logic [10:1]        sw_ff;

   logic               out_v_ff;
   logic signed [31:0] sin_ff;
   logic signed [31:0] cos_ff;

   logic signed [32:0] bs;
   logic signed [32:0] bc;
   logic signed [32:0] s0;
   logic signed [32:0] c0;
   logic signed [32:0] sin_in;
   logic signed [32:0] cos_in;

   always_comb begin
      bs = sacc_ff[10];
      bc = cacc_ff[10] - $signed({3'b000, term_of(10, p_ff[10])});
      s0 = sw_ff[10] ? bc : bs;
      c0 = sw_ff[10] ? bs : bc;
      case (q_ff[10])
         2'd0: begin
            sin_in = s0;
            cos_in = c0;
         end
         2'd1: begin
            sin_in = c0;
            cos_in = -s0;
         end
         2'd2: begin
            sin_in = -s0;
            cos_in = -c0;
         end
         default: begin
            sin_in = -c0;
            cos_in = s0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_v_ff <= 1'b0;
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else begin
         red_v_ff <= in_valid;
         v_ff[1]  <= red_v_ff;
         for (int k = 2; k <= 10; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
         out_v_ff <= v_ff[10];
      end
   end

   always_ff @(posedge clock) begin
      red_r_ff   <= r;
      red_q_ff   <= q;
      p_ff[1]    <= x;
      x_ff[1]    <= x;
      sacc_ff[1] <= '0;
      cacc_ff[1] <= $signed(TRS_Q30_ONE);
      q_ff[1]    <= red_q_ff;
      sw_ff[1]   <= sw;
      for (int k = 1; k <= 9; k++) begin
         p_ff[k+1]  <= umul30(p_ff[k], x_ff[k]);
         x_ff[k+1]  <= x_ff[k];
         q_ff[k+1]  <= q_ff[k];
         sw_ff[k+1] <= sw_ff[k];
         if ((k % 2) == 1) begin
            cacc_ff[k+1] <= cacc_ff[k];
            if ((k % 4) == 1) begin
               sacc_ff[k+1] <= sacc_ff[k] + $signed({3'b000, term_of(k, p_ff[k])});
            end else begin
               sacc_ff[k+1] <= sacc_ff[k] - $signed({3'b000, term_of(k, p_ff[k])});
            end
         end else begin
            sacc_ff[k+1] <= sacc_ff[k];
            if ((k % 4) == 0) begin
               cacc_ff[k+1] <= cacc_ff[k] + $signed({3'b000, term_of(k, p_ff[k])});
            end else begin
               cacc_ff[k+1] <= cacc_ff[k] - $signed({3'b000, term_of(k, p_ff[k])});
            end
         end
      end
      sin_ff <= 32'(sin_in);
      cos_ff <= 32'(cos_in);
   end

   assign out_valid = out_v_ff;
   assign sin_q30   = sin_ff;
   assign cos_q30   = cos_ff;

endmodule

>>> design/trs_transform_matrix_builder.sv
// Top level of the TRS model matrix builder: rotation, scale and column output.
`include "assert_macros.svh"

// One word holds a position, three Euler angles and a scale; the block answers with the
// four columns of M = T * Rx * Ry * Rz * S, column 0 first, one column per cycle, each
// marked by rsp_strobe for one cycle. Column 0 passes the input stage, the sine and cosine
// lanes, rotation products, column sequencer and scale and output registers. A word is
// taken when start is high and busy is low; busy is then held high by a down-counter
// that spaces the words so the output sends all four columns of each. The datapath is a
// fixed 19-stage pipeline with no back pressure: results must be taken as they come.
module trs_transform_matrix_builder #(
   parameter int VALUE_WIDTH = trs_pkg::TRS_VALUE_WIDTH
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic signed [VALUE_WIDTH-1:0]              req_pos_x,
   input  logic signed [VALUE_WIDTH-1:0]              req_pos_y,
   input  logic signed [VALUE_WIDTH-1:0]              req_pos_z,
   input  logic signed [trs_pkg::TRS_ANGLE_WIDTH-1:0] req_angle_x,
   input  logic signed [trs_pkg::TRS_ANGLE_WIDTH-1:0] req_angle_y,
   input  logic signed [trs_pkg::TRS_ANGLE_WIDTH-1:0] req_angle_z,
   input  logic signed [VALUE_WIDTH-1:0]              req_scale_x,
   input  logic signed [VALUE_WIDTH-1:0]              req_scale_y,
   input  logic signed [VALUE_WIDTH-1:0]              req_scale_z,
   output logic                                       rsp_strobe,
   output logic [1:0]                                 rsp_column_index,
   output logic signed [VALUE_WIDTH-1:0]              rsp_row0,
   output logic signed [VALUE_WIDTH-1:0]              rsp_row1,
   output logic signed [VALUE_WIDTH-1:0]              rsp_row2,
   output logic signed [VALUE_WIDTH-1:0]              rsp_row3,
   output logic                                       rsp_last_column
);
   import trs_pkg::*;

   localparam int VW  = VALUE_WIDTH;
   localparam int PSW = 6 * VW;
   localparam int SXW = (VW > 31) ? VW : 31;
   localparam int HIW = SXW - 30;
   localparam int PHW = 32 + HIW;
   localparam int MW  = PHW + 1;
   localparam int DLY = TRS_SC_LATENCY + 3;
   localparam logic [VW-1:0] ONE_SAT =
      (VW >= 18) ? VW'(65536) : {1'b0, {(VW-1){1'b1}}};
   localparam logic [MW-1:0] LIM_NEG = MW'(1) << (VW - 1);
   localparam logic [MW-1:0] LIM_POS = LIM_NEG - MW'(1);
   localparam logic [61:0]   HALF62  = 62'h2000_0000;

   function automatic logic signed [31:0] smul30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic [30:0] ma;
      logic [30:0] mb;
      logic [61:0] pr;
      logic [31:0] mg;
      ma = 31'((a < 0) ? -a : a);
      mb = 31'((b < 0) ? -b : b);
      pr = 62'(ma) * 62'(mb) + HALF62;
      mg = 32'(pr >> 30);
      return ((a < 0) != (b < 0)) ? -$signed(mg) : $signed(mg);
   endfunction

   // issue control
   logic [1:0] busy_cnt_ff;
   logic       accept;

   assign accept = start && !busy;
   assign busy   = busy_cnt_ff != 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_cnt_ff <= 2'd0;
      end else if (accept) begin
         busy_cnt_ff <= 2'd3;
      end else if (busy_cnt_ff != 2'd0) begin
         busy_cnt_ff <= busy_cnt_ff - 2'd1;
      end
   end

   // input stage
   logic                              in_v_ff;
   logic signed [TRS_ANGLE_WIDTH-1:0] ang_x_ff;
   logic signed [TRS_ANGLE_WIDTH-1:0] ang_y_ff;
   logic signed [TRS_ANGLE_WIDTH-1:0] ang_z_ff;
   logic [PSW-1:0]                    ps_ff;
   logic [PSW-1:0]                    dl_ff [1:DLY];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ang_x_ff <= req_angle_x;
         ang_y_ff <= req_angle_y;
         ang_z_ff <= req_angle_z;
         ps_ff    <= {req_scale_z, req_scale_y, req_scale_x, req_pos_z, req_pos_y, req_pos_x};
      end
      dl_ff[1] <= ps_ff;
      for (int k = 2; k <= DLY; k++) begin
         dl_ff[k] <= dl_ff[k-1];
      end
   end

   // sine and cosine lanes
   logic               sc_v_x;
   logic               sc_v_y;
   logic               sc_v_z;
   logic signed [31:0] sa;
   logic signed [31:0] ca;
   logic signed [31:0] sb;
   logic signed [31:0] cb;
   logic signed [31:0] sc;
   logic signed [31:0] cc;

   trs_sincos u_sincos_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_v_ff),
      .angle     (ang_x_ff),
      .out_valid (sc_v_x),
      .sin_q30   (sa),
      .cos_q30   (ca)
   );

   trs_sincos u_sincos_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_v_ff),
      .angle     (ang_y_ff),
      .out_valid (sc_v_y),
      .sin_q30   (sb),
      .cos_q30   (cb)
   );

   trs_sincos u_sincos_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_v_ff),
      .angle     (ang_z_ff),
      .out_valid (sc_v_z),
      .sin_q30   (sc),
      .cos_q30   (cc)
   );

   // rotation products
   logic               r1_v_ff;
   logic signed [31:0] r1_sab_ff, r1_cab_ff, r1_cbcc_ff, r1_cbsc_ff, r1_casc_ff;
   logic signed [31:0] r1_cacc_ff, r1_sasc_ff, r1_sacb_ff, r1_cacb_ff, r1_sacc_ff;
   logic signed [31:0] r1_sb_ff, r1_cc_ff, r1_sc_ff;

   logic               r2_v_ff;
   logic signed [31:0] r2_sabcc_ff, r2_sabsc_ff, r2_cabcc_ff, r2_cabsc_ff;
   logic signed [31:0] r2_cbcc_ff, r2_cbsc_ff, r2_casc_ff, r2_cacc_ff, r2_sasc_ff;
   logic signed [31:0] r2_sacb_ff, r2_cacb_ff, r2_sacc_ff, r2_sb_ff;

   logic               r3_v_ff;
   logic signed [33:0] rm_ff [0:2][0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_v_ff <= 1'b0;
         r2_v_ff <= 1'b0;
         r3_v_ff <= 1'b0;
      end else begin
         r1_v_ff <= sc_v_x;
         r2_v_ff <= r1_v_ff;
         r3_v_ff <= r2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      r1_sab_ff  <= smul30(sa, sb);
      r1_cab_ff  <= smul30(ca, sb);
      r1_cbcc_ff <= smul30(cb, cc);
      r1_cbsc_ff <= smul30(cb, sc);
      r1_casc_ff <= smul30(ca, sc);
      r1_cacc_ff <= smul30(ca, cc);
      r1_sasc_ff <= smul30(sa, sc);
      r1_sacb_ff <= smul30(sa, cb);
      r1_cacb_ff <= smul30(ca, cb);
      r1_sacc_ff <= smul30(sa, cc);
      r1_sb_ff   <= sb;
      r1_cc_ff   <= cc;
      r1_sc_ff   <= sc;

      r2_sabcc_ff <= smul30(r1_sab_ff, r1_cc_ff);
      r2_sabsc_ff <= smul30(r1_sab_ff, r1_sc_ff);
      r2_cabcc_ff <= smul30(r1_cab_ff, r1_cc_ff);
      r2_cabsc_ff <= smul30(r1_cab_ff, r1_sc_ff);
      r2_cbcc_ff  <= r1_cbcc_ff;
      r2_cbsc_ff  <= r1_cbsc_ff;
      r2_casc_ff  <= r1_casc_ff;
      r2_cacc_ff  <= r1_cacc_ff;
      r2_sasc_ff  <= r1_sasc_ff;
      r2_sacb_ff  <= r1_sacb_ff;
      r2_cacb_ff  <= r1_cacb_ff;
      r2_sacc_ff  <= r1_sacc_ff;
      r2_sb_ff    <= r1_sb_ff;

      rm_ff[0][0] <= 34'(r2_cbcc_ff);
      rm_ff[0][1] <= -34'(r2_cbsc_ff);
      rm_ff[0][2] <= 34'(r2_sb_ff);
      rm_ff[1][0] <= 34'(r2_sabcc_ff) + 34'(r2_casc_ff);
      rm_ff[1][1] <= 34'(r2_cacc_ff) - 34'(r2_sabsc_ff);
      rm_ff[1][2] <= -34'(r2_sacb_ff);
      rm_ff[2][0] <= 34'(r2_sasc_ff) - 34'(r2_cabcc_ff);
      rm_ff[2][1] <= 34'(r2_cabsc_ff) + 34'(r2_sacc_ff);
      rm_ff[2][2] <= 34'(r2_cacb_ff);
   end

   // column sequencer
   logic               iss_v_ff;
   logic [1:0]         iss_col_ff;
   logic signed [33:0] hold_rm_ff [0:2][0:2];
   logic [PSW-1:0]     hold_ps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_v_ff   <= 1'b0;
         iss_col_ff <= 2'd0;
      end else if (r3_v_ff) begin
         iss_v_ff   <= 1'b1;
         iss_col_ff <= 2'd0;
      end else if (iss_v_ff) begin
         if (iss_col_ff == TRS_COL_LAST) begin
            iss_v_ff <= 1'b0;
         end
         iss_col_ff <= iss_col_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (r3_v_ff) begin
         hold_rm_ff <= rm_ff;
         hold_ps_ff <= dl_ff[DLY];
      end
   end

   // scale multiply, split as low 30 bits and the rest of the scale magnitude
   logic signed [33:0] e_sel [0:2];
   logic [VW-1:0]      s_sel;
   logic               sneg;
   logic [VW-1:0]      smag;
   logic [SXW-1:0]     smag_x;
   logic [31:0]        emag [0:2];
   logic               neg_in [0:2];
   logic [61:0]        plo_in [0:2];
   logic [PHW-1:0]     phi_in [0:2];

   always_comb begin
      case (iss_col_ff)
         2'd0: begin
            s_sel = hold_ps_ff[3*VW +: VW];
            for (int i = 0; i < 3; i++) e_sel[i] = hold_rm_ff[i][0];
         end
         2'd1: begin
            s_sel = hold_ps_ff[4*VW +: VW];
            for (int i = 0; i < 3; i++) e_sel[i] = hold_rm_ff[i][1];
         end
         2'd2: begin
            s_sel = hold_ps_ff[5*VW +: VW];
            for (int i = 0; i < 3; i++) e_sel[i] = hold_rm_ff[i][2];
         end
         default: begin
            s_sel = '0;
            for (int i = 0; i < 3; i++) e_sel[i] = '0;
         end
      endcase
      sneg   = s_sel[VW-1];
      smag   = sneg ? -s_sel : s_sel;
      smag_x = SXW'(smag);
      for (int i = 0; i < 3; i++) begin
         emag[i]   = 32'((e_sel[i] < 0) ? -e_sel[i] : e_sel[i]);
         neg_in[i] = (e_sel[i] < 0) != sneg;
         plo_in[i] = 62'(emag[i]) * 62'(smag_x[29:0]);
         phi_in[i] = PHW'(emag[i]) * PHW'(smag_x[SXW-1:30]);
      end
   end

   logic                 sc1_v_ff;
   logic [1:0]           sc1_col_ff;
   logic                 sc1_neg_ff [0:2];
   logic [61:0]          sc1_plo_ff [0:2];
   logic [PHW-1:0]       sc1_phi_ff [0:2];
   logic [3*VW-1:0]      sc1_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sc1_v_ff <= 1'b0;
      end else begin
         sc1_v_ff <= iss_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      sc1_col_ff <= iss_col_ff;
      sc1_neg_ff <= neg_in;
      sc1_plo_ff <= plo_in;
      sc1_phi_ff <= phi_in;
      sc1_pos_ff <= hold_ps_ff[3*VW-1:0];
   end

   // round, saturate, select column
   logic [MW-1:0] mag  [0:2];
   logic [MW-1:0] lim  [0:2];
   logic [MW-1:0] sat  [0:2];
   logic [VW-1:0] elem [0:2];
   logic [VW-1:0] row_in [0:3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i]  = MW'(sc1_phi_ff[i]) + MW'((sc1_plo_ff[i] + HALF62) >> 30);
         lim[i]  = sc1_neg_ff[i] ? LIM_NEG : LIM_POS;
         sat[i]  = (mag[i] > lim[i]) ? lim[i] : mag[i];
         elem[i] = sc1_neg_ff[i] ? VW'(-sat[i]) : VW'(sat[i]);
      end
      if (sc1_col_ff == TRS_COL_LAST) begin
         row_in[0] = sc1_pos_ff[0 +: VW];
         row_in[1] = sc1_pos_ff[VW +: VW];
         row_in[2] = sc1_pos_ff[2*VW +: VW];
         row_in[3] = ONE_SAT;
      end else begin
         row_in[0] = elem[0];
         row_in[1] = elem[1];
         row_in[2] = elem[2];
         row_in[3] = '0;
      end
   end

   logic          out_v_ff;
   logic [1:0]    out_col_ff;
   logic [VW-1:0] out_row_ff [0:3];
   logic          out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= sc1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_col_ff  <= sc1_col_ff;
      out_row_ff  <= row_in;
      out_last_ff <= sc1_col_ff == TRS_COL_LAST;
   end

   assign rsp_strobe       = out_v_ff;
   assign rsp_column_index = out_col_ff;
   assign rsp_row0         = $signed(out_row_ff[0]);
   assign rsp_row1         = $signed(out_row_ff[1]);
   assign rsp_row2         = $signed(out_row_ff[2]);
   assign rsp_row3         = $signed(out_row_ff[3]);
   assign rsp_last_column  = out_last_ff;

   `ASSERT_NEXT(a_busy_after_start, clock, reset, start && !busy, busy)
   `ASSERT_IMPLY(a_lanes_aligned, clock, reset, sc_v_x, sc_v_y && sc_v_z)
   `ASSERT_IMPLY(a_last_on_final, clock, reset, rsp_strobe, rsp_last_column == (rsp_column_index == TRS_COL_LAST))
   `ASSERT_NEXT(a_columns_in_row, clock, reset, rsp_strobe && rsp_column_index != TRS_COL_LAST, rsp_strobe && rsp_column_index == $past(rsp_column_index) + 2'd1)

endmodule

>>> bench/trs_transform_matrix_builder_test.sv
// Self-checking testbench of the TRS model matrix builder: directed and random words.
`timescale 1ns / 100ps

module trs_transform_matrix_builder_test;
   import trs_pkg::*;

   localparam int VW = TRS_VALUE_WIDTH;
   localparam int AW = TRS_ANGLE_WIDTH;
   localparam int RANDOM_WORDS = 440;
   localparam longint CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [VW-1:0] px, py, pz;
      logic [AW-1:0] ax, ay, az;
      logic [VW-1:0] sx, sy, sz;
   } trs_word_type;

   typedef struct packed {
      logic [1:0]    col;
      logic [VW-1:0] r0, r1, r2, r3;
      logic          last;
   } column_type;

   localparam logic [63:0] VMASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - VW);
   localparam logic [63:0] VSIGN = 64'd1 << (VW - 1);
   localparam logic [63:0] RADK = TRS_PI_Q60 / 64'd23040;
   localparam logic [63:0] ONE30 = 64'd1 << 30;
   localparam logic [63:0] HALF30 = 64'd1 << 29;
   localparam int QUARTER = 11520;
   localparam int EIGHTH = 5760;
   localparam int FULL = 46080;

   class column_scoreboard;
      column_type pending[$];
      int         mismatches;
      int         columns_seen;

      function logic [63:0] mag(longint v);
         return v < 0 ? 64'd0 - 64'(v) : 64'(v);
      endfunction

      function logic [63:0] umul(logic [63:0] a, logic [63:0] b);
         return (a * b + HALF30) >> 30;
      endfunction

      function longint smul(longint a, longint b);
         logic [63:0] m;
         m = umul(mag(a), mag(b));
         return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
      endfunction

      function void series(logic [63:0] r, output longint s, output longint c);
         logic [63:0] x, p[11];
         x = (r * RADK + HALF30) >> 30;
         p[1] = x;
         for (int k = 2; k <= 10; k++) p[k] = umul(p[k-1], x);
         s = longint'(x) - longint'(p[3] / 6) + longint'(p[5] / 120)
           - longint'(p[7] / 5040) + longint'(p[9] / 362880);
         c = longint'(ONE30) - longint'(p[2] / 2) + longint'(p[4] / 24)
           - longint'(p[6] / 720) + longint'(p[8] / 40320)
           - longint'(p[10] / 3628800);
      endfunction

      function void sin_cos(logic [AW-1:0] raw, output longint s, output longint c);
         int a, m, q, r;
         longint bs, bc;
         a = int'($signed(raw));
         m = a % FULL;
         if (m < 0) m += FULL;
         q = m / QUARTER;
         r = m - q * QUARTER;
         if (r > EIGHTH) series(64'(QUARTER - r), bc, bs);
         else series(64'(r), bs, bc);
         case (q)
            0: begin s = bs; c = bc; end
            1: begin s = bc; c = -bs; end
            2: begin s = -bs; c = -bc; end
            default: begin s = -bc; c = bs; end
         endcase
      endfunction

      function logic [VW-1:0] saturate(bit neg, logic [63:0] m);
         logic [63:0] lim;
         lim = neg ? VSIGN : VSIGN - 1;
         if (m > lim) m = lim;
         return neg ? VW'((64'd0 - m) & VMASK) : VW'(m & VMASK);
      endfunction

      function logic [VW-1:0] scaled(longint e, logic [VW-1:0] sbits);
         logic [63:0] sv, smag, emag, hi, lo, prod;
         bit sneg, neg;
         sv = 64'(sbits) & VMASK;
         sneg = (sv & VSIGN) != 0;
         smag = sneg ? ((64'd0 - sv) & VMASK) : sv;
         emag = mag(e);
         neg = (e < 0) != sneg;
         hi = smag >> 30;
         lo = (emag * (smag & (ONE30 - 1)) + HALF30) >> 30;
         if (hi != 0 && emag > 64'hFFFF_FFFF_FFFF_FFFF / hi) return saturate(neg, '1);
         prod = emag * hi;
         if (prod > 64'hFFFF_FFFF_FFFF_FFFF - lo) return saturate(neg, '1);
         return saturate(neg, prod + lo);
      endfunction

      function void note_word(trs_word_type w);
         longint sa, ca, sb, cb, sc, cc, sab, cab;
         longint rot[3][3];
         logic [VW-1:0] sc_axis[3];
         column_type c;
         sin_cos(w.ax, sa, ca);
         sin_cos(w.ay, sb, cb);
         sin_cos(w.az, sc, cc);
         sab = smul(sa, sb);
         cab = smul(ca, sb);
         rot[0][0] = smul(cb, cc);
         rot[0][1] = -smul(cb, sc);
         rot[0][2] = sb;
         rot[1][0] = smul(sab, cc) + smul(ca, sc);
         rot[1][1] = smul(ca, cc) - smul(sab, sc);
         rot[1][2] = -smul(sa, cb);
         rot[2][0] = smul(sa, sc) - smul(cab, cc);
         rot[2][1] = smul(cab, sc) + smul(sa, cc);
         rot[2][2] = smul(ca, cb);
         sc_axis = '{w.sx, w.sy, w.sz};
         for (int j = 0; j < 3; j++) begin
            c.col = 2'(j);
            c.r0 = scaled(rot[0][j], sc_axis[j]);
            c.r1 = scaled(rot[1][j], sc_axis[j]);
            c.r2 = scaled(rot[2][j], sc_axis[j]);
            c.r3 = '0;
            c.last = 1'b0;
            pending.push_back(c);
         end
         c.col = TRS_COL_LAST;
         c.r0 = w.px;
         c.r1 = w.py;
         c.r2 = w.pz;
         c.r3 = saturate(1'b0, 64'd65536);
         c.last = 1'b1;
         pending.push_back(c);
      endfunction

      function void check_column(column_type got);
         column_type want;
         columns_seen++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected column %0d", got.col);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: want col %0d %h %h %h %h last %b, %s",
                  want.col, want.r0, want.r1, want.r2, want.r3, want.last,
                  $sformatf("got col %0d %h %h %h %h last %b",
                     got.col, got.r0, got.r1, got.r2, got.r3, got.last));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [VW-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [AW-1:0] req_angle_x = '0, req_angle_y = '0, req_angle_z = '0;
   logic signed [VW-1:0] req_scale_x = '0, req_scale_y = '0, req_scale_z = '0;
   logic rsp_strobe, rsp_last_column;
   logic [1:0] rsp_column_index;
   logic signed [VW-1:0] rsp_row0, rsp_row1, rsp_row2, rsp_row3;

   column_scoreboard board = new();
   longint cycles = 0;
   int words_sent = 0;

   trs_transform_matrix_builder uut (
      .clock, .reset, .start, .busy,
      .req_pos_x, .req_pos_y, .req_pos_z,
      .req_angle_x, .req_angle_y, .req_angle_z,
      .req_scale_x, .req_scale_y, .req_scale_z,
      .rsp_strobe, .rsp_column_index, .rsp_row0, .rsp_row1, .rsp_row2, .rsp_row3,
      .rsp_last_column
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      column_type got;
      cycles++;
      if (!reset && rsp_strobe) begin
         got.col = rsp_column_index;
         got.r0 = rsp_row0;
         got.r1 = rsp_row1;
         got.r2 = rsp_row2;
         got.r3 = rsp_row3;
         got.last = rsp_last_column;
         board.check_column(got);
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [VW-1:0] rand_value();
      case ($urandom_range(0, 5))
         0: return VW'($urandom);
         1: return VW'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
         2: return VW'(32'sh0001_0000);
         3: return {1'b0, {(VW-1){1'b1}}};
         4: return {1'b1, {(VW-1){1'b0}}};
         default: return VW'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      endcase
   endfunction

   function automatic logic [AW-1:0] rand_angle();
      case ($urandom_range(0, 4))
         0: return AW'($urandom);
         1: return AW'(QUARTER * $urandom_range(0, 8) - 4 * QUARTER);
         default: return AW'($signed($urandom_range(0, 2 * FULL)) - FULL);
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after the accepting edge
   task automatic send_word(trs_word_type w, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_pos_x <= w.px; req_pos_y <= w.py; req_pos_z <= w.pz;
      req_angle_x <= w.ax; req_angle_y <= w.ay; req_angle_z <= w.az;
      req_scale_x <= w.sx; req_scale_y <= w.sy; req_scale_z <= w.sz;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_word(w);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_directed(logic [AW-1:0] a, logic [AW-1:0] b, logic [AW-1:0] c,
                                logic [VW-1:0] p, logic [VW-1:0] s);
      trs_word_type w;
      w = '{p, ~p, p ^ 32'h5A5A_0000, a, b, c, s, ~s, s >>> 1};
      send_word(w, 0);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   initial begin
      trs_word_type w;
      int gap;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_directed('0, '0, '0, '0, 32'sh0001_0000);
      send_directed(17'sd46080, -17'sd46080, 17'sd11520, 32'h7FFF_FFFF, 32'h8000_0000);
      send_directed(17'h0FFFF, 17'h10000, 17'h1FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_directed(17'sd5760, 17'sd5761, 17'sd5759, 32'hFFFF_FFFF, 32'h0000_0001);
      send_directed(17'sd23040, 17'sd34560, -17'sd11520, 32'h1234_5678, 32'hFFFF_0000);
      send_directed(17'sd17280, 17'sd28800, 17'sd40320, 32'h0, 32'h4000_0000);
      send_directed(17'sd1, -17'sd1, 17'sd45000, 32'h00FF_00FF, 32'hC000_0000);
      send_directed(17'sd1000, 17'sd2000, 17'sd3000, 32'hFFFE_0000, 32'h0002_8000);
      // back-to-back words, no gap
      for (int k = 0; k < 8; k++)
         send_directed(AW'(k * 7000), AW'(-k * 5000), AW'(k * 11520), VW'(k << 16),
                       VW'(k == 0 ? 1 : -k << 15));
      drain();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         w.px = rand_value(); w.py = rand_value(); w.pz = rand_value();
         w.ax = rand_angle(); w.ay = rand_angle(); w.az = rand_angle();
         w.sx = rand_value(); w.sy = rand_value(); w.sz = rand_value();
         gap = (n / 50) % 3 == 1 ? 0 : $urandom_range(0, 5);
         if (n == RANDOM_WORDS / 2) drain();
         send_word(w, gap);
      end

      drain();
      repeat (30) @(posedge clock);
      $display("sent %0d words, checked %0d columns across all angle quadrants", words_sent,
               board.columns_seen);
      $display("%0d mismatches", board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
